// ===== design/mfr_pkg.sv =====
// Package for the meter frame receiver: frame codes, parse phases, status codes
// and the structs passed between the receiver modules.
// No dependencies.
package mfr_pkg;

    // Line codes of the frame
    localparam logic [7:0] START_CODE     = 8'h68;
    localparam logic [7:0] END_CODE       = 8'h16;
    localparam logic [7:0] LEN_VALVE_LONG = 8'h24;
    localparam logic [7:0] LEN_VALVE_SHRT = 8'h02;
    localparam logic [7:0] LEN_ACK_LONG   = 8'h05;
    localparam logic [7:0] LEN_ACK_SHRT   = 8'h04;

    // Configuration reset values
    localparam logic [15:0] TIMEOUT_RST = 16'd100;
    localparam logic [7:0]  TYPE_RST    = 8'h41;
    localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_TYPE    = 1'b1;

    // Word opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Parse phases, one-hot
    typedef enum logic [13:0] {
        PH_IDLE  = 14'b00000000000001,
        PH_TYPE  = 14'b00000000000010,
        PH_ADDR0 = 14'b00000000000100,
        PH_ADDR1 = 14'b00000000001000,
        PH_ADDR2 = 14'b00000000010000,
        PH_ADDR3 = 14'b00000000100000,
        PH_EXT0  = 14'b00000001000000,
        PH_EXT1  = 14'b00000010000000,
        PH_FUNC  = 14'b00000100000000,
        PH_CTRL  = 14'b00001000000000,
        PH_LEN   = 14'b00010000000000,
        PH_DATA  = 14'b00100000000000,
        PH_CSUM  = 14'b01000000000000,
        PH_END   = 14'b10000000000000
    } t_phase;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_VALVE    = 2'd0,
        ST_ACK      = 2'd1,
        ST_CSUM_ERR = 2'd2,
        ST_BAD_LEN  = 2'd3
    } t_status;

    // One input word
    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } t_item;

    // Configuration registers
    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  expected_type;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic [1:0]  frame_status;
        logic [31:0] meter_address;
        logic [15:0] ext_address;
        logic [7:0]  function_byte;
        logic [7:0]  control_byte;
        logic [7:0]  data_length;
    } t_result;

endpackage

// ===== design/mfr_rx_if.sv =====
// Input channel of the meter frame receiver: valid/ready plus opcode and byte.
// No dependencies.
interface mfr_rx_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// ===== design/mfr_frame_if.sv =====
// Result channel of the meter frame receiver: valid/ready plus the frame fields.
// No dependencies.
interface mfr_frame_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [31:0] meter_address;
    logic [15:0] ext_address;
    logic [7:0]  function_byte;
    logic [7:0]  control_byte;
    logic [7:0]  data_length;

    modport source (output valid, output frame_status, output meter_address,
                    output ext_address, output function_byte, output control_byte,
                    output data_length, input ready);
    modport sink   (input valid, input frame_status, input meter_address,
                    input ext_address, input function_byte, input control_byte,
                    input data_length, output ready);
endinterface

// ===== design/mfr_parser.sv =====
// Frame parser: phase register, checksum, idle counter and field capture.
// Evaluates one registered word per step. Depends on mfr_pkg.
module mfr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  mfr_pkg::t_item   i_item,
    input  mfr_pkg::t_cfg    i_cfg,
    output logic             o_has_result,
    output mfr_pkg::t_result o_result
);

    mfr_pkg::t_phase r_phase, n_phase, eff_phase;
    logic [7:0]      r_remain, n_remain, dec_remain;
    logic [15:0]     r_idle, n_idle;
    logic [7:0]      r_sum, n_sum;
    logic [31:0]     r_addr, n_addr;
    logic [15:0]     r_ext, n_ext;
    logic [7:0]      r_func, n_func;
    logic [7:0]      r_ctrl, n_ctrl;
    logic [7:0]      r_len, n_len;
    logic            r_sum_ok, n_sum_ok;
    logic [7:0]      b;
    logic            is_byte;
    mfr_pkg::t_status status;

    assign b          = i_item.rx_byte;
    assign is_byte    = (i_item.opcode == mfr_pkg::OP_BYTE);
    assign dec_remain = r_remain - 8'd1;

    // Restart the parse when the line stayed idle too long
    always_comb begin
        if (r_idle > i_cfg.timeout_ticks) begin
            eff_phase = mfr_pkg::PH_IDLE;
        end else begin
            eff_phase = r_phase;
        end
    end

    // Next state for one word
    always_comb begin
        n_phase  = r_phase;
        n_remain = r_remain;
        n_idle   = r_idle;
        n_sum    = r_sum;
        n_addr   = r_addr;
        n_ext    = r_ext;
        n_func   = r_func;
        n_ctrl   = r_ctrl;
        n_len    = r_len;
        n_sum_ok = r_sum_ok;
        o_has_result = 1'b0;
        if (!is_byte) begin
            // count idle time, saturating
            if (r_idle != mfr_pkg::IDLE_MAX) begin
                n_idle = r_idle + 16'd1;
            end
        end else begin
            n_phase = eff_phase;
            unique case (eff_phase)
                mfr_pkg::PH_IDLE: begin
                    if (b == mfr_pkg::START_CODE) begin
                        n_sum   = b;
                        n_addr  = '0;
                        n_ext   = '0;
                        n_idle  = '0;
                        n_phase = mfr_pkg::PH_TYPE;
                    end
                end
                mfr_pkg::PH_TYPE: begin
                    if (b == i_cfg.expected_type) begin
                        n_sum   = r_sum + b;
                        n_idle  = '0;
                        n_phase = mfr_pkg::PH_ADDR0;
                    end
                end
                mfr_pkg::PH_ADDR0: begin
                    n_addr[7:0] = b;
                    n_sum   = r_sum + b;
                    n_idle  = '0;
                    n_phase = mfr_pkg::PH_ADDR1;
                end
                mfr_pkg::PH_ADDR1: begin
                    n_addr[15:8] = b;
                    n_sum   = r_sum + b;
                    n_idle  = '0;
                    n_phase = mfr_pkg::PH_ADDR2;
                end
                mfr_pkg::PH_ADDR2: begin
                    n_addr[23:16] = b;
                    n_sum   = r_sum + b;
                    n_idle  = '0;
                    n_phase = mfr_pkg::PH_ADDR3;
                end
                mfr_pkg::PH_ADDR3: begin
                    n_addr[31:24] = b;
                    n_sum   = r_sum + b;
                    n_idle  = '0;
                    n_phase = mfr_pkg::PH_EXT0;
                end
                mfr_pkg::PH_EXT0: begin
                    n_ext[7:0] = b;
                    n_sum   = r_sum + b;
                    n_idle  = '0;
                    n_phase = mfr_pkg::PH_EXT1;
                end
                mfr_pkg::PH_EXT1: begin
                    n_ext[15:8] = b;
                    n_sum   = r_sum + b;
                    n_idle  = '0;
                    n_phase = mfr_pkg::PH_FUNC;
                end
                mfr_pkg::PH_FUNC: begin
                    n_func  = b;
                    n_sum   = r_sum + b;
                    n_idle  = '0;
                    n_phase = mfr_pkg::PH_CTRL;
                end
                mfr_pkg::PH_CTRL: begin
                    n_ctrl  = b;
                    n_sum   = r_sum + b;
                    n_idle  = '0;
                    n_phase = mfr_pkg::PH_LEN;
                end
                mfr_pkg::PH_LEN: begin
                    n_len    = b;
                    n_remain = b;
                    n_sum    = r_sum + b;
                    n_idle   = '0;
                    n_phase  = (b != 8'd0) ? mfr_pkg::PH_DATA : mfr_pkg::PH_CSUM;
                end
                mfr_pkg::PH_DATA: begin
                    n_remain = dec_remain;
                    n_sum    = r_sum + b;
                    n_idle   = '0;
                    n_phase  = (dec_remain == 8'd0) ? mfr_pkg::PH_CSUM
                                                    : mfr_pkg::PH_DATA;
                end
                mfr_pkg::PH_CSUM: begin
                    n_sum_ok = (b == r_sum);
                    n_idle   = '0;
                    n_phase  = mfr_pkg::PH_END;
                end
                mfr_pkg::PH_END: begin
                    // drop the frame silently on a bad end code
                    n_idle       = '0;
                    n_phase      = mfr_pkg::PH_IDLE;
                    o_has_result = (b == mfr_pkg::END_CODE);
                end
                default: begin
                    n_phase = mfr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Classify the finished frame
    always_comb begin
        if (!r_sum_ok) begin
            status = mfr_pkg::ST_CSUM_ERR;
        end else begin
            case (r_len) inside
                mfr_pkg::LEN_VALVE_LONG, mfr_pkg::LEN_VALVE_SHRT: status = mfr_pkg::ST_VALVE;
                mfr_pkg::LEN_ACK_LONG, mfr_pkg::LEN_ACK_SHRT:     status = mfr_pkg::ST_ACK;
                default:                                          status = mfr_pkg::ST_BAD_LEN;
            endcase
        end
    end

    assign o_result.frame_status  = status;
    assign o_result.meter_address = r_addr;
    assign o_result.ext_address   = r_ext;
    assign o_result.function_byte = r_func;
    assign o_result.control_byte  = r_ctrl;
    assign o_result.data_length   = r_len;

    // Advance the parser state on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mfr_pkg::PH_IDLE;
            r_remain <= '0;
            r_idle   <= '0;
            r_sum    <= '0;
            r_addr   <= '0;
            r_ext    <= '0;
            r_func   <= '0;
            r_ctrl   <= '0;
            r_len    <= '0;
            r_sum_ok <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_idle   <= n_idle;
            r_sum    <= n_sum;
            r_addr   <= n_addr;
            r_ext    <= n_ext;
            r_func   <= n_func;
            r_ctrl   <= n_ctrl;
            r_len    <= n_len;
            r_sum_ok <= n_sum_ok;
        end
    end

    // A finished frame always returns the parser to the start hunt
    a_result_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_has_result |=> r_phase == mfr_pkg::PH_IDLE)
        else $error("parser did not restart after a frame");

    // Ticks never move the phase
    a_tick_holds_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.opcode == mfr_pkg::OP_TICK |=> $stable(r_phase))
        else $error("tick changed the parse phase");

    // Data phase always has bytes left to take
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == mfr_pkg::PH_DATA |-> r_remain != 8'd0)
        else $error("data phase with zero bytes left");

    // Ticks never produce a result
    a_tick_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.opcode == mfr_pkg::OP_TICK |-> !o_has_result)
        else $error("tick produced a result");

endmodule

// ===== design/mfr_result_reg.sv =====
// Output register of the meter frame receiver: holds one result word until taken.
// Depends on mfr_pkg and mfr_frame_if.
module mfr_result_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mfr_pkg::t_result i_result,
    output logic             o_free,
    mfr_frame_if.source      o_frame
);

    logic             r_vld;
    mfr_pkg::t_result r_res;

    assign o_free = !r_vld || o_frame.ready;

    // Hold the word until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_frame.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_frame.valid         = r_vld;
    assign o_frame.frame_status  = r_res.frame_status;
    assign o_frame.meter_address = r_res.meter_address;
    assign o_frame.ext_address   = r_res.ext_address;
    assign o_frame.function_byte = r_res.function_byte;
    assign o_frame.control_byte  = r_res.control_byte;
    assign o_frame.data_length   = r_res.data_length;

endmodule

// ===== design/meter_frame_receiver_core.sv =====
// Meter-bus frame receiver top level: input register, parser, output register.
// Depends on mfr_pkg, mfr_rx_if, mfr_frame_if, mfr_parser, mfr_result_reg.
//
// Usage:
//   i_rx carries one word per handshake: opcode 0 with a received line byte,
//   or opcode 1 for one timer tick. o_frame carries one result word for each
//   frame that ends with a good end code: status, address, extended address,
//   function, control and length bytes. Frames with a bad end code are dropped.
//   The configuration port writes timeout_ticks (index 0) and expected_type
//   (index 1); write only while no word is in flight.
// Timing:
//   A word is taken into the input register and parsed from there; the step
//   that parses it loads its result into the output register and raises
//   o_frame.valid. One word per cycle is sustained unless a finished frame
//   stalls on o_frame; the input and output registers each hold one word.
// Reset and stall:
//   Reset clears the parser to the start hunt, sets timeout_ticks to 100 and
//   expected_type to 0x41. While a result waits on o_frame, words that give no
//   result keep flowing; a word that completes a frame waits in the input
//   register, and i_rx.ready drops only then.
module meter_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfr_rx_if.sink      i_rx,
    mfr_frame_if.source o_frame,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    logic             r_in_vld;
    mfr_pkg::t_item   r_in;
    mfr_pkg::t_cfg    r_cfg;
    logic             has_result;
    logic             out_free;
    logic             step;
    mfr_pkg::t_result result;

    // Advance the input word unless its result has nowhere to go
    assign step       = r_in_vld && (!has_result || out_free);
    assign i_rx.ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in.opcode  <= i_rx.opcode;
            r_in.rx_byte <= i_rx.rx_byte;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= mfr_pkg::TIMEOUT_RST;
            r_cfg.expected_type <= mfr_pkg::TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mfr_pkg::CFG_TIMEOUT: r_cfg.timeout_ticks <= i_cfg_wdata;
                mfr_pkg::CFG_TYPE:    r_cfg.expected_type <= i_cfg_wdata[7:0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    mfr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_item       (r_in),
        .i_cfg        (r_cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    mfr_result_reg u_result_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && has_result),
        .i_result (result),
        .o_free   (out_free),
        .o_frame  (o_frame)
    );

endmodule
